// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define HME_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HME_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hme_pkg.sv =====
`timescale 1ns / 1ps
package hme_pkg;

  localparam int LEVELS_DEF     = 256;
  localparam int COUNT_BITS_DEF = 22;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int Q_DEPTH        = 2;

  // input kinds as seen on the channel
  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_COUNT = 3'd2;
  localparam logic [2:0] KIND_BUILD = 3'd3;
  localparam logic [2:0] KIND_REMAP = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  index;
    logic [15:0] value;
    logic [7:0]  level;
  } hme_item_t;

endpackage

// ===== hdl/hme_in_if.sv =====
`timescale 1ns / 1ps
interface hme_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  target_index;
  logic [15:0] target_value;
  logic [7:0]  pixel;

  modport source (output valid, kind, target_index, target_value, pixel, input ready);
  modport sink (input valid, kind, target_index, target_value, pixel, output ready);
endinterface

// ===== hdl/hme_out_if.sv =====
`timescale 1ns / 1ps
interface hme_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mapped_pixel;
  logic       map_ready;

  modport source (output valid, mapped_pixel, map_ready, input ready);
  modport sink (input valid, mapped_pixel, map_ready, output ready);
endinterface

// ===== hdl/hme_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hme_front #(
  parameter int LEVELS = hme_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hme_in_if.sink            in_ch,
  output hme_pkg::hme_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import hme_pkg::*;

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW  = $clog2(Q_DEPTH + 1);

  hme_item_t       entries [Q_DEPTH];
  logic [QAW-1:0]  wp;
  logic [QAW-1:0]  rp;
  logic [CW-1:0]   count;
  logic            push;
  logic            keep;
  logic            accept;
  hme_item_t       item;

  // classify: drop unknown kinds and out-of-range target loads, clamp pixel levels to LEVELS-1
  always_comb begin
    item.op    = in_ch.kind;
    item.index = in_ch.target_index;
    item.value = in_ch.target_value;
    if ({1'b0, in_ch.pixel} >= 9'(LEVELS)) begin
      item.level = 8'(LEVELS - 1);
    end else begin
      item.level = in_ch.pixel;
    end
    case (in_ch.kind)
      KIND_CLEAR, KIND_COUNT, KIND_BUILD, KIND_REMAP: keep = 1'b1;
      KIND_LOAD: keep = ({1'b0, in_ch.target_index} < 9'(LEVELS));
      default: keep = 1'b0;
    endcase
  end

  assign in_ch.ready = (count != CW'(Q_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && keep;
  assign q_valid     = (count != '0);
  assign q_item      = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QAW'(Q_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (q_pop) begin
        rp <= (rp == QAW'(Q_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(push) - CW'(q_pop && q_valid);
    end
  end

  `HME_ASSERT(a_no_pop_empty, q_pop |-> count != '0, "pop from empty queue")
  `HME_ASSERT(a_count_bound, count <= CW'(Q_DEPTH), "queue count overflow")
  `HME_ASSERT(a_push_moves_wp, push |=> wp != $past(wp) || Q_DEPTH == 1, "write pointer stuck")

endmodule

// ===== hdl/hme_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hme_back #(
  parameter int LEVELS     = hme_pkg::LEVELS_DEF,
  parameter int COUNT_BITS = hme_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = hme_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  hme_pkg::hme_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  hme_out_if.source          out_ch
);
  import hme_pkg::*;

  localparam int LW    = $clog2(LEVELS);
  localparam int CB    = COUNT_BITS;
  localparam int CUM_W = CB + LW;
  localparam int PRD_W = CUM_W + 8;
  localparam int NUM_W = PRD_W + FRAC_BITS + 1;
  localparam int DCW   = $clog2(NUM_W + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CNT_WR = 4'd1;
  localparam logic [3:0] S_RMP    = 4'd2;
  localparam logic [3:0] S_B_RD   = 4'd3;
  localparam logic [3:0] S_B_ACC  = 4'd4;
  localparam logic [3:0] S_B_MUL  = 4'd5;
  localparam logic [3:0] S_B_DIV0 = 4'd6;
  localparam logic [3:0] S_B_DIV  = 4'd7;
  localparam logic [3:0] S_B_SRCH = 4'd8;
  localparam logic [3:0] S_B_DONE = 4'd9;

  logic [3:0]       state;
  logic [CB-1:0]    bin_mem [LEVELS];
  logic [15:0]      tgt_mem [LEVELS];
  logic [7:0]       map_mem [LEVELS];
  logic [LEVELS-1:0] bin_vld;
  logic [CB-1:0]    bin_rd;
  logic             bin_rd_vld;
  logic [15:0]      tgt_rd;
  logic [7:0]       map_rd;
  logic             bin_re, tgt_re, map_re, bin_we, map_we, tgt_we;
  logic [LW-1:0]    bin_raddr, tgt_raddr, map_raddr, map_waddr;
  logic [CB-1:0]    bin_wdata;
  logic [7:0]       map_wdata;
  logic [CB-1:0]    total;
  logic [LW-1:0]    cur_lvl;
  logic [LW-1:0]    m;
  logic [CUM_W-1:0] cum;
  logic [PRD_W-1:0] prod;
  logic [CB:0]      rem;
  logic [NUM_W-1:0] quo;
  logic [DCW-1:0]   dcnt;
  logic [LW:0]      ncnt;
  logic             cmp_vld;
  logic [LW-1:0]    cmp_idx;
  logic [NUM_W-1:0] best_dist;
  logic [LW-1:0]    best;
  logic             out_vld;
  logic [7:0]       out_px;
  logic             out_mr;
  logic             out_free;
  logic [CB-1:0]    bin_val;
  logic [CB:0]      rem_sh;
  logic             rem_ge;
  logic [NUM_W-1:0] g_ext, gap;
  logic             take_new;
  logic [LW-1:0]    best_sel;
  logic             srch_issue;

  assign out_free = !out_vld || out_ch.ready;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign bin_val  = bin_rd_vld ? bin_rd : '0;

  // restoring divider step
  assign rem_sh = {rem[CB-1:0], quo[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, total};

  // distance to the current target entry
  assign g_ext    = NUM_W'(tgt_rd);
  assign gap      = (g_ext >= quo) ? g_ext - quo : quo - g_ext;
  assign take_new = (cmp_idx == '0) || (gap < best_dist);
  assign best_sel = take_new ? cmp_idx : best;
  assign srch_issue = (state == S_B_SRCH) && (ncnt < (LW+1)'(LEVELS));

  // memory port control
  always_comb begin
    bin_re    = 1'b0;
    bin_raddr = m;
    tgt_re    = srch_issue;
    tgt_raddr = ncnt[LW-1:0];
    tgt_we    = 1'b0;
    map_re    = 1'b0;
    map_raddr = q_item.level[LW-1:0];
    map_we    = 1'b0;
    map_waddr = m;
    map_wdata = 8'(best_sel);
    bin_we    = (state == S_CNT_WR);
    bin_wdata = (bin_val == {CB{1'b1}}) ? bin_val : bin_val + 1'b1;
    if (q_pop) begin
      case (q_item.op)
        KIND_LOAD: tgt_we = 1'b1;
        KIND_COUNT: begin
          bin_re    = 1'b1;
          bin_raddr = q_item.level[LW-1:0];
        end
        KIND_REMAP: map_re = 1'b1;
        default: ;
      endcase
    end
    if (state == S_B_RD) begin
      bin_re = 1'b1;
    end
    if (cmp_vld && cmp_idx == LW'(LEVELS - 1)) begin
      map_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[cur_lvl] <= bin_wdata;
    end
    if (bin_re) begin
      bin_rd <= bin_mem[bin_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[q_item.index[LW-1:0]] <= q_item.value;
    end
    if (tgt_re) begin
      tgt_rd <= tgt_mem[tgt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd <= map_mem[map_raddr];
    end
  end

  // bin valid bits stand in for clearing the bin memory
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld    <= '0;
      bin_rd_vld <= 1'b0;
    end else begin
      if (bin_re) begin
        bin_rd_vld <= bin_vld[bin_raddr];
      end
      if (q_pop && q_item.op == KIND_CLEAR) begin
        bin_vld <= '0;
      end else if (bin_we) begin
        bin_vld[cur_lvl] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_lvl <= q_item.level[LW-1:0];
    end
    case (state)
      S_B_ACC: cum <= cum + CUM_W'(bin_val);
      S_B_MUL: prod <= {cum, 8'd0} - {8'd0, cum};
      S_B_DIV0: begin
        rem  <= '0;
        dcnt <= DCW'(NUM_W);
        if (total == '0) begin
          quo <= '0;
        end else begin
          quo <= {1'b0, prod, {FRAC_BITS{1'b0}}} + NUM_W'(total >> 1);
        end
      end
      S_B_DIV: begin
        rem  <= rem_ge ? rem_sh - {1'b0, total} : rem_sh;
        quo  <= {quo[NUM_W-2:0], rem_ge};
        dcnt <= dcnt - 1'b1;
      end
      default: ;
    endcase
    if (q_pop && q_item.op == KIND_BUILD) begin
      cum <= '0;
    end
    if (state == S_B_SRCH) begin
      cmp_idx <= ncnt[LW-1:0];
    end
    if (cmp_vld) begin
      best      <= best_sel;
      best_dist <= take_new ? gap : best_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      total   <= '0;
      m       <= '0;
      ncnt    <= '0;
      cmp_vld <= 1'b0;
      out_vld <= 1'b0;
      out_px  <= '0;
      out_mr  <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_vld <= 1'b0;
      end
      cmp_vld <= srch_issue;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.op)
              KIND_CLEAR: total <= '0;
              KIND_COUNT: begin
                if (total != {CB{1'b1}}) begin
                  total <= total + 1'b1;
                end
                state <= S_CNT_WR;
              end
              KIND_BUILD: begin
                m     <= '0;
                state <= S_B_RD;
              end
              KIND_REMAP: state <= S_RMP;
              default: ;
            endcase
          end
        end
        S_CNT_WR: state <= S_IDLE;
        S_RMP: begin
          if (out_free) begin
            out_vld <= 1'b1;
            out_px  <= map_rd;
            out_mr  <= 1'b0;
            state   <= S_IDLE;
          end
        end
        S_B_RD:  state <= S_B_ACC;
        S_B_ACC: state <= S_B_MUL;
        S_B_MUL: state <= S_B_DIV0;
        S_B_DIV0: begin
          ncnt  <= '0;
          state <= (total == '0) ? S_B_SRCH : S_B_DIV;
        end
        S_B_DIV: begin
          if (dcnt == DCW'(1)) begin
            state <= S_B_SRCH;
          end
        end
        S_B_SRCH: begin
          if (srch_issue) begin
            ncnt <= ncnt + 1'b1;
          end
          if (cmp_vld && cmp_idx == LW'(LEVELS - 1)) begin
            if (m == LW'(LEVELS - 1)) begin
              state <= S_B_DONE;
            end else begin
              m     <= m + 1'b1;
              state <= S_B_RD;
            end
          end
        end
        S_B_DONE: begin
          if (out_free) begin
            out_vld <= 1'b1;
            out_px  <= 8'd0;
            out_mr  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_vld;
  assign out_ch.mapped_pixel = out_px;
  assign out_ch.map_ready    = out_mr;

  `HME_ASSERT(a_build_result_zero, out_vld && out_mr |-> out_px == 8'd0,
              "build result carries a pixel")
  `HME_ASSERT(a_cmp_in_search, cmp_vld |-> state == S_B_SRCH, "compare outside search")
  `HME_ASSERT(a_div_count, state == S_B_DIV |-> dcnt != '0, "divider ran past its count")

endmodule

// ===== hdl/histogram_matching_engine_top.sv =====
`timescale 1ns / 1ps
// one transaction at a time in the back end: clear and load complete in the idle state; count reads the bin,
// then writes it back in S_CNT_WR. remap: the map entry is read into map_rd as the transaction leaves the queue,
// then registered to the output once the output register is free. build: per level, a bin read, accumulate,
//   multiply, then the bit-serial divider and the one-entry-a-cycle target search
// synchronous active-high reset clears the histogram, pixel count, queue and output;
//   target curve and level map hold garbage until written
module histogram_matching_engine_top #(
  parameter int LEVELS     = hme_pkg::LEVELS_DEF,
  parameter int COUNT_BITS = hme_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = hme_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hme_in_if.sink    in_ch,
  hme_out_if.source out_ch
);
  import hme_pkg::*;

  // queue between decode and execution
  hme_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  // front: accepts transactions, drops unknown kinds, clamps levels, buffers two items
  hme_front #(
    .LEVELS(LEVELS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  // back: histogram, target and map memories, build sequencer, output register
  hme_back #(
    .LEVELS    (LEVELS),
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
